/* rtl/core/aes_cbc_pkg.sv */
package aes_cbc_pkg;

  localparam int unsigned HalfW   = 64;
  localparam int unsigned BlockW  = 128;
  localparam int unsigned NRounds = 10;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 3'd0,
    RegKeyLow  = 3'd1,
    RegIvHigh  = 3'd2,
    RegIvLow   = 3'd3,
    RegDecrypt = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [HalfW-1:0] data_high;
    logic [HalfW-1:0] data_low;
    logic             start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] result_high;
    logic [HalfW-1:0] result_low;
  } out_item_t;

  localparam logic [7:0] FwdSbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] Rcon [NRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xt(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift_fwd(block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*c) -: 8] = FwdSbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t sub_shift_inv(block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*c) -: 8] = InvSbox[get_byte(s, r + 4*((c + 3*r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t mix_fwd(block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[BlockW-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      o[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      o[BlockW-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return o;
  endfunction

  function automatic logic [7:0] mul_e(logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return a8 ^ a4 ^ a2;
  endfunction

  function automatic logic [7:0] mul_b(logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return a8 ^ a2 ^ a;
  endfunction

  function automatic logic [7:0] mul_d(logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return a8 ^ a4 ^ a;
  endfunction

  function automatic logic [7:0] mul_9(logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return a8 ^ a;
  endfunction

  function automatic block_t mix_inv(block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[BlockW-1-8*(4*c)   -: 8] = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
      o[BlockW-1-8*(4*c+1) -: 8] = mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3);
      o[BlockW-1-8*(4*c+2) -: 8] = mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3);
      o[BlockW-1-8*(4*c+3) -: 8] = mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3);
    end
    return o;
  endfunction

  function automatic block_t next_round_key(block_t k, logic [7:0] rc);
    block_t o;
    logic [31:0] t;
    t = {FwdSbox[k[23:16]] ^ rc, FwdSbox[k[15:8]], FwdSbox[k[7:0]], FwdSbox[k[31:24]]};
    o[127:96] = k[127:96] ^ t;
    o[95:64]  = k[95:64] ^ o[127:96];
    o[63:32]  = k[63:32] ^ o[95:64];
    o[31:0]   = k[31:0] ^ o[63:32];
    return o;
  endfunction

endpackage

/* rtl/core/aes_cbc_if.sv */
interface aes_cbc_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/aes_cbc_key_sched.sv */
module aes_cbc_key_sched (
  input  aes_cbc_pkg::block_t key_i,
  output aes_cbc_pkg::block_t rkeys_o [aes_cbc_pkg::NRounds+1]
);
  import aes_cbc_pkg::*;

  assign rkeys_o[0] = key_i;

  for (genvar r = 0; r < NRounds; r++) begin : g_round
    assign rkeys_o[r+1] = next_round_key(rkeys_o[r], Rcon[r]);
  end
endmodule

/* rtl/core/aes_cbc_datapath.sv */
module aes_cbc_datapath (
  input  aes_cbc_pkg::block_t din_i,
  input  logic                decrypt_i,
  input  aes_cbc_pkg::block_t rkeys_i [aes_cbc_pkg::NRounds+1],
  output aes_cbc_pkg::block_t dout_o
);
  import aes_cbc_pkg::*;

  block_t enc_s [NRounds+1];
  block_t dec_s [NRounds+1];

  assign enc_s[0] = din_i ^ rkeys_i[0];
  assign dec_s[0] = din_i ^ rkeys_i[NRounds];

  for (genvar r = 1; r <= NRounds; r++) begin : g_round
    if (r < NRounds) begin : g_mid
      assign enc_s[r] = mix_fwd(sub_shift_fwd(enc_s[r-1])) ^ rkeys_i[r];
      assign dec_s[r] = mix_inv(sub_shift_inv(dec_s[r-1]) ^ rkeys_i[NRounds-r]);
    end else begin : g_last
      assign enc_s[r] = sub_shift_fwd(enc_s[r-1]) ^ rkeys_i[r];
      assign dec_s[r] = sub_shift_inv(dec_s[r-1]) ^ rkeys_i[0];
    end
  end

  assign dout_o = decrypt_i ? dec_s[NRounds] : enc_s[NRounds];
endmodule

/* rtl/core/aes128_cbc_block_engine.sv */
// channel  dir  payload                                  accepted when
// in_if    in   data_high, data_low, start_of_message    valid && ready
// out_if   out  result_high, result_low                  valid && ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i          cfg_we_i high
//
// one item per cycle while out_if takes results; a result appears in the cycle after its item is taken
// the ten rounds and key schedule are one unrolled pass into the result register
// in_if.ready is high whenever the result register is empty or being taken
// rst_ni clears key, iv, mode, chaining block and the output valid
module aes128_cbc_block_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aes_cbc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [aes_cbc_pkg::HalfW-1:0]       cfg_wdata_i,
  aes_cbc_if.sink                             in_if,
  aes_cbc_if.source                           out_if
);
  import aes_cbc_pkg::*;

  logic [HalfW-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic             decrypt_q;
  block_t           chain_q, chain_d;
  block_t           res_q, res_d;
  logic             valid_q;

  in_item_t  in_item;
  out_item_t out_item;
  block_t    data_blk, chain_sel, core_in, core_out;
  block_t    rkeys [NRounds+1];
  logic      accept;

  assign in_item   = in_if.data;
  assign data_blk  = {in_item.data_high, in_item.data_low};
  assign chain_sel = in_item.start_of_message ? {iv_hi_q, iv_lo_q} : chain_q;
  assign core_in   = decrypt_q ? data_blk : data_blk ^ chain_sel;

  assign in_if.ready = !valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  aes_cbc_key_sched u_key_sched (
    .key_i   ({key_hi_q, key_lo_q}),
    .rkeys_o (rkeys)
  );

  aes_cbc_datapath u_datapath (
    .din_i     (core_in),
    .decrypt_i (decrypt_q),
    .rkeys_i   (rkeys),
    .dout_o    (core_out)
  );

  always_comb begin
    res_d   = decrypt_q ? core_out ^ chain_sel : core_out;
    chain_d = decrypt_q ? data_blk : core_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      iv_hi_q   <= '0;
      iv_lo_q   <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyHigh: key_hi_q  <= cfg_wdata_i;
        RegKeyLow:  key_lo_q  <= cfg_wdata_i;
        RegIvHigh:  iv_hi_q   <= cfg_wdata_i;
        RegIvLow:   iv_lo_q   <= cfg_wdata_i;
        RegDecrypt: decrypt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        chain_q <= chain_d;
        valid_q <= 1'b1;
      end else if (out_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_item.result_high = res_q[BlockW-1 -: HalfW];
  assign out_item.result_low  = res_q[HalfW-1:0];
  assign out_if.valid = valid_q;
  assign out_if.data  = out_item;
endmodule

/* verif/tb_aes128_cbc_block_engine.sv */
module tb_aes128_cbc_block_engine;
  import aes_cbc_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  class cbc_scoreboard;
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         decrypt;
    logic [127:0] chain;
    logic [127:0] rkey [11];
    out_item_t    expected_q [$];
    int           errors;

    function new();
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      decrypt = 1'b0; chain = '0; errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] v);
      case (idx)
        RegKeyHigh: key_hi = v;
        RegKeyLow:  key_lo = v;
        RegIvHigh:  iv_hi = v;
        RegIvLow:   iv_lo = v;
        RegDecrypt: decrypt = v[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
        if (b[0]) acc ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        b = b >> 1;
      end
      return acc;
    endfunction

    function void expand_key();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = 32'({key_hi, key_lo} >> (96 - 32 * i));
      for (int i = 4; i < 44; i++) begin
        t = w[i-1];
        if (i % 4 == 0) begin
          t = {FwdSbox[t[23:16]] ^ rc, FwdSbox[t[15:8]], FwdSbox[t[7:0]], FwdSbox[t[31:24]]};
          rc = gmul(rc, 8'h02);
        end
        w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // byte i of the state sits at bits 127-8i, column-major
    function logic [127:0] sub_rows(logic [127:0] s, bit inv);
      logic [127:0] o;
      logic [7:0]   b;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          b = s[127 - 8 * (r + 4 * ((c + (inv ? 3 : 1) * r) % 4)) -: 8];
          o[127 - 8 * (r + 4 * c) -: 8] = inv ? InvSbox[b] : FwdSbox[b];
        end
      end
      return o;
    endfunction

    function logic [127:0] mix(logic [127:0] s, bit inv);
      logic [127:0] o;
      logic [7:0]   m [4];
      logic [7:0]   acc;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc = '0;
          for (int k = 0; k < 4; k++)
            acc ^= gmul(s[127 - 8 * (4 * c + k) -: 8], m[(k - r + 4) % 4]);
          o[127 - 8 * (4 * c + r) -: 8] = acc;
        end
      end
      return o;
    endfunction

    function void note_input(in_item_t it);
      logic [127:0] prev, s;
      prev = it.start_of_message ? {iv_hi, iv_lo} : chain;
      expand_key();
      if (decrypt) begin
        s = {it.data_high, it.data_low} ^ rkey[10];
        for (int r = 9; r >= 0; r--) begin
          s = sub_rows(s, 1'b1) ^ rkey[r];
          if (r > 0) s = mix(s, 1'b1);
        end
        s ^= prev;
        chain = {it.data_high, it.data_low};
      end else begin
        s = {it.data_high, it.data_low} ^ prev ^ rkey[0];
        for (int r = 1; r <= 10; r++) begin
          s = sub_rows(s, 1'b0);
          if (r < 10) s = mix(s, 1'b0);
          s ^= rkey[r];
        end
        chain = s;
      end
      expected_q.push_back(out_item_t'(s));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_high !== want.result_high)
        report($sformatf("result_high %h, want %h", got.result_high, want.result_high));
      if (got.result_low !== want.result_low)
        report($sformatf("result_low %h, want %h", got.result_low, want.result_low));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [HalfW-1:0]    cfg_wdata;
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;
  int unsigned         idle_cycles = 0;
  cbc_scoreboard       sb;

  aes_cbc_if #(.Width($bits(in_item_t)))  in_ch ();
  aes_cbc_if #(.Width($bits(out_item_t))) out_ch ();

  aes128_cbc_block_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // item monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_item_t'(in_ch.data));
      if (out_ch.valid && out_ch.ready) sb.check_result(out_item_t'(out_ch.data));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic som);
    in_item_t it;
    it.data_high = hi;
    it.data_low = lo;
    it.start_of_message = som;
    if (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned len;
    sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chaining block is zero after reset
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    drain();

    // standard known-answer key and block
    write_reg(RegKeyHigh, 64'h0001020304050607);
    write_reg(RegKeyLow, 64'h08090a0b0c0d0e0f);
    end_cfg();
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    send_block('1, '1, 1'b0);
    send_block('0, '0, 1'b0);
    drain();

    write_reg(RegIvHigh, '1);
    write_reg(RegIvLow, '1);
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    end_cfg();
    send_block('0, '0, 1'b1);
    send_block(64'h8000000000000001, 64'h0123456789abcdef, 1'b0);
    drain();

    // mode flips mid-message, chain carried over
    write_reg(RegDecrypt, 64'd1);
    end_cfg();
    send_block('1, '0, 1'b0);
    send_block('0, '1, 1'b1);
    send_block(64'hfedcba9876543210, '1, 1'b0);
    drain();

    // only bit 0 of the mode counts; indexes past the list do nothing
    write_reg(RegDecrypt, 64'hffff_ffff_ffff_fffe);
    for (int i = int'(RegDecrypt) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), '1);
    end_cfg();
    send_block('0, '1, 1'b1);
    send_block('1, '0, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(RegKeyHigh, rand64());
      write_reg(RegKeyLow, rand64());
      write_reg(RegIvHigh, rand64());
      write_reg(RegIvLow, rand64());
      write_reg(RegDecrypt, {$urandom, $urandom});
      end_cfg();
      calm = (ph == 5);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 180; n += len) begin
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
          send_block(rand64(), rand64(), k == 0 && $urandom_range(9) != 0);
        if (ph == 7 && n > 90 && n < 110) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (sb.expected_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
      calm = 1'b0;
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/aes_cbc_pkg.sv
rtl/core/aes_cbc_if.sv
rtl/core/aes_cbc_key_sched.sv
rtl/core/aes_cbc_datapath.sv
rtl/core/aes128_cbc_block_engine.sv
verif/tb_aes128_cbc_block_engine.sv
